[hdl/progressive_photon_stat_update_unit_assert.svh]
// ----------------------------------------------------------------------------
// Progressive photon statistic update: assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef PROGRESSIVE_PHOTON_STAT_UPDATE_UNIT_ASSERT_SVH
`define PROGRESSIVE_PHOTON_STAT_UPDATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define PPSU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ppsu assertion failed");
// An implication that must hold at every clock edge outside reset.
`define PPSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppsu implication failed");
`else
`define PPSU_ASSERT(label, clk, rst, prop)
`define PPSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

[hdl/ppsu_pkg.sv]
// ----------------------------------------------------------------------------
// Progressive photon statistic update: package
// Shared types, constants and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsu_pkg;

  // Number of gather points held in the statistics memory.
  localparam int POINTS   = 65536;
  localparam int POINT_AW = $clog2(POINTS);

  // Width of one statistics memory word: radius, count and three flux sums.
  localparam int MEM_W = 168;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // pi in Q2.30, rounded.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_ALPHA          = 2'd0;
  localparam logic [1:0] CFG_INITIAL_RADIUS = 2'd1;
  localparam logic [1:0] CFG_TOTAL_EMITTED  = 2'd2;

  typedef logic [POINT_AW-1:0] paddr_t;

  typedef enum logic {
    KIND_UPDATE,
    KIND_BACKGROUND
  } kind_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [31:0] initial_radius;
    logic [47:0] total_emitted;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              first_pass;
    logic [15:0]       point_index;
    logic [23:0]       photons_found;
    logic [2:0][31:0]  flux;
    logic [2:0][31:0]  emission;
  } item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

[hdl/progressive_photon_stat_update_unit.sv]
// ----------------------------------------------------------------------------
// Progressive photon statistic update unit
// Per-gather-point radius, count and flux update with radiance estimate.
// ----------------------------------------------------------------------------
// Items are taken whenever busy is low and wait in a four-beat queue; busy is
// high while the queue holds four items. The back end works on one item at a
// time. A background item is handled in the idle state and its result shows
// on the next cycle. An update item holds it while the 32-step ratio divider,
// the 32-step square root, three flux scaling steps, four area steps, four
// denominator multiply-accumulate steps and the 64-step contribution divider
// run in turn. Divider and square root are skipped when the ratio is one or
// more, and the contribution divider is skipped when the denominator is zero
// or 64 bits or wider; an item with no photons at all also skips the flux
// scaling and the radius update. Each result beat is shown for a single cycle
// on result_valid and must be taken then, since the receiver cannot stall.
// Results leave in the order items came in.
`default_nettype none

`include "progressive_photon_stat_update_unit_assert.svh"

module progressive_photon_stat_update_unit import ppsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] point_index,
  input  wire logic        first_pass,
  input  wire logic        background,
  input  wire logic [23:0] photons_found,
  input  wire logic [31:0] flux_red,
  input  wire logic [31:0] flux_green,
  input  wire logic [31:0] flux_blue,
  input  wire logic [31:0] emission_red,
  input  wire logic [31:0] emission_green,
  input  wire logic [31:0] emission_blue,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output logic             result_valid,
  output logic [15:0]      result_index,
  output logic [31:0]      contrib_red,
  output logic [31:0]      contrib_green,
  output logic [31:0]      contrib_blue,
  output logic             saturated
);

  cfg_t   cfg;
  item_t  push_item;
  item_t  head;
  qstat_t qstat;
  logic   push;
  logic   pop;

  assign busy = qstat.full;

  // Front end: configuration and item intake.
  ppsu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .q_full         (qstat.full),
    .point_index    (point_index),
    .first_pass     (first_pass),
    .background     (background),
    .photons_found  (photons_found),
    .flux_red       (flux_red),
    .flux_green     (flux_green),
    .flux_blue      (flux_blue),
    .emission_red   (emission_red),
    .emission_green (emission_green),
    .emission_blue  (emission_blue),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cfg_ready      (cfg_ready),
    .cfg            (cfg),
    .push           (push),
    .push_item      (push_item)
  );

  // Queue between front and back.
  ppsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // Back end: statistics update and radiance estimate.
  ppsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_index  (result_index),
    .contrib_red   (contrib_red),
    .contrib_green (contrib_green),
    .contrib_blue  (contrib_blue),
    .saturated     (saturated)
  );

  // The back end never takes an item from an empty queue.
  `PPSU_ASSERT_IMPL(a_pop_not_empty, clk, rst, pop, !qstat.empty)
  // An item pushed into an empty queue is visible on the next cycle.
  `PPSU_ASSERT_IMPL(a_push_lands, clk, rst, push && qstat.empty && !pop, ##1 !qstat.empty)
  // A write to the alpha register lands in the register file.
  `PPSU_ASSERT(a_alpha_write, clk, rst,
    (cfg_valid && cfg_index == CFG_ALPHA) |=> (cfg.alpha == $past(cfg_data[15:0])))

endmodule

`default_nettype wire

[hdl/ppsu_front.sv]
// ----------------------------------------------------------------------------
// Progressive photon statistic update: front end
// Holds the configuration registers and classifies incoming items.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsu_front import ppsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        q_full,
  input  wire logic [15:0] point_index,
  input  wire logic        first_pass,
  input  wire logic        background,
  input  wire logic [23:0] photons_found,
  input  wire logic [31:0] flux_red,
  input  wire logic [31:0] flux_green,
  input  wire logic [31:0] flux_blue,
  input  wire logic [31:0] emission_red,
  input  wire logic [31:0] emission_green,
  input  wire logic [31:0] emission_blue,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output logic             cfg_ready,
  output cfg_t             cfg,
  output logic             push,
  output item_t            push_item
);

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha          <= 16'd45875;
      cfg.initial_radius <= 32'd65536;
      cfg.total_emitted  <= 48'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA:          cfg.alpha          <= cfg_data[15:0];
        CFG_INITIAL_RADIUS: cfg.initial_radius <= cfg_data[31:0];
        CFG_TOTAL_EMITTED:  cfg.total_emitted  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept and classify an item.
  assign push = start && !q_full;

  always_comb begin
    push_item.kind          = background ? KIND_BACKGROUND : KIND_UPDATE;
    push_item.first_pass    = first_pass;
    push_item.point_index   = point_index;
    push_item.photons_found = photons_found;
    push_item.flux          = {flux_blue, flux_green, flux_red};
    push_item.emission      = {emission_blue, emission_green, emission_red};
  end

endmodule

`default_nettype wire

[hdl/ppsu_queue.sv]
// ----------------------------------------------------------------------------
// Progressive photon statistic update: item queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsu_queue import ppsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output qstat_t     stat
);

  item_t            slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QAW+1)'(QDEPTH));

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ppsu_back.sv]
// ----------------------------------------------------------------------------
// Progressive photon statistic update: back end
// Sequencer with iterative dividers and square root, the statistics
// memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsu_back import ppsu_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire item_t  head,
  input  wire qstat_t qstat,
  output logic        pop,
  output logic        result_valid,
  output logic [15:0] result_index,
  output logic [31:0] contrib_red,
  output logic [31:0] contrib_green,
  output logic [31:0] contrib_blue,
  output logic        saturated
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_LOAD, S_CALC, S_CHECK, S_DIV, S_SQRT, S_SCALE, S_RAD,
    S_WRITE, S_AREA0, S_AREA1, S_AREA2, S_AREA3, S_DEN0, S_DEN1, S_DEN2,
    S_DEN3, S_QDIV, S_FIN
  } state_t;

  state_t            state;
  item_t             cur;
  logic [31:0]       r;
  logic [39:0]       n;
  logic [2:0][31:0]  fl;
  logic [39:0]       am;
  logic [40:0]       den;
  logic [40:0]       newn;
  logic [41:0]       rem;
  logic [32:0]       ratio;
  logic [32:0]       s;
  logic [5:0]        cnt;
  logic [63:0]       sq_x;
  logic [63:0]       sq_res;
  logic [63:0]       sq_bit;
  logic [1:0]        chan;
  logic [63:0]       rr;
  logic [63:0]       pa0;
  logic [63:0]       pa1;
  logic [63:0]       area;
  logic [63:0]       asr;
  logic [111:0]      acc;
  logic [63:0]       d;
  logic              dbig;
  logic              sat;
  logic [2:0][64:0]  qr;
  logic [2:0][63:0]  qq;

  logic [MEM_W-1:0]  mem [POINTS];
  logic [MEM_W-1:0]  rd_data;
  logic              mem_we;
  paddr_t            addr;

  // Combinational helpers.
  logic [41:0]       rem_sh;
  logic              div_ge;
  logic [32:0]       ratio_next;
  logic [63:0]       sq_trial;
  logic              sq_ge;
  logic [63:0]       sq_res_next;
  logic [32:0]       fsum;
  logic [64:0]       lo_prod;
  logic [33:0]       fscaled;
  logic [64:0]       rad_prod;
  logic [95:0]       p96;
  logic [63:0]       dprod;
  logic [2:0][64:0]  qr_sh;
  logic [2:0]        q_ge;
  logic [2:0][32:0]  e_sum;

  assign addr   = paddr_t'(cur.point_index);
  assign mem_we = (state == S_WRITE);
  assign pop    = (state == S_IDLE) && !qstat.empty;

  // Statistics memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= {r, n, fl[2], fl[1], fl[0]};
    end
    rd_data <= mem[addr];
  end

  always_comb begin
    // Ratio divider step.
    rem_sh      = {rem[40:0], 1'b0};
    div_ge      = (rem_sh >= {1'b0, den});
    ratio_next  = {ratio[31:0], div_ge};
    // Square root step.
    sq_trial    = sq_res + sq_bit;
    sq_ge       = (sq_x >= sq_trial);
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    // Flux scaling for the channel in turn.
    fsum        = {1'b0, fl[chan]} + {1'b0, cur.flux[chan]};
    lo_prod     = {33'd0, fsum[31:0]} * {32'd0, ratio};
    fscaled     = {1'b0, lo_prod[64:32]} + (fsum[32] ? {1'b0, ratio} : 34'd0);
    // Radius scaling.
    rad_prod    = {33'd0, r} * {32'd0, s};
    // Area partial-product sum.
    p96         = {32'd0, pa0} + {pa1, 32'd0};
    // Denominator: emitted total times the top 16 bits of the area still left.
    dprod       = cfg.total_emitted * asr[63:48];
    // Contribution divider step and final sum, per channel.
    for (int ch = 0; ch < 3; ch++) begin
      qr_sh[ch] = {qr[ch][63:0], qq[ch][63]};
      q_ge[ch]  = (qr_sh[ch] >= {1'b0, d});
      e_sum[ch] = {1'b0, qq[ch][31:0]} + {1'b0, cur.emission[ch]};
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            cur <= head;
            sat <= 1'b0;
            if (head.kind == KIND_BACKGROUND) begin
              result_valid  <= 1'b1;
              result_index  <= head.point_index;
              contrib_red   <= head.emission[0];
              contrib_green <= head.emission[1];
              contrib_blue  <= head.emission[2];
              saturated     <= 1'b0;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (cur.first_pass) begin
            r  <= cfg.initial_radius;
            n  <= '0;
            fl <= '0;
          end else begin
            r  <= rd_data[167:136];
            n  <= rd_data[135:96];
            fl <= rd_data[95:0];
          end
          am    <= cfg.alpha * cur.photons_found;
          state <= S_CALC;
        end
        S_CALC: begin
          den   <= {1'b0, n} + {1'b0, cur.photons_found, 16'd0};
          newn  <= {1'b0, n} + {1'b0, am};
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (den == '0) begin
            fl    <= '0;
            state <= S_WRITE;
          end else if (newn >= den) begin
            ratio <= {1'b1, 32'd0};
            s     <= {1'b1, 32'd0};
            chan  <= '0;
            state <= S_SCALE;
          end else begin
            rem   <= {1'b0, newn};
            ratio <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
          ratio <= ratio_next;
          cnt   <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            sq_x   <= {ratio_next[31:0], 32'd0};
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_x <= sq_x - sq_trial;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            s     <= {1'b0, sq_res_next[31:0]};
            chan  <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (fscaled[33:32] != 2'd0) begin
            fl[chan] <= '1;
            sat      <= 1'b1;
          end else begin
            fl[chan] <= fscaled[31:0];
          end
          chan <= chan + 1'b1;
          if (chan == 2'd2) begin
            state <= S_RAD;
          end
        end
        S_RAD: begin
          r     <= rad_prod[63:32];
          n     <= newn[40] ? '1 : newn[39:0];
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_AREA0;
        end
        S_AREA0: begin
          rr    <= r * r;
          state <= S_AREA1;
        end
        S_AREA1: begin
          pa0   <= rr[31:0] * PI_Q30;
          state <= S_AREA2;
        end
        S_AREA2: begin
          pa1   <= rr[63:32] * PI_Q30;
          state <= S_AREA3;
        end
        S_AREA3: begin
          area  <= (p96[95:94] != 2'd0) ? '1 : p96[93:30];
          state <= S_DEN0;
        end
        S_DEN0: begin
          acc   <= '0;
          asr   <= area;
          cnt   <= '0;
          state <= S_DEN1;
        end
        // Four multiply-accumulate steps, most significant area chunk first.
        S_DEN1: begin
          acc <= {acc[95:0], 16'd0} + {48'd0, dprod};
          asr <= {asr[47:0], 16'd0};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd3) begin
            state <= S_DEN2;
          end
        end
        S_DEN2: begin
          dbig  <= (acc[111:64] != '0);
          d     <= acc[63:0];
          state <= S_DEN3;
        end
        S_DEN3: begin
          if (!dbig && d == '0) begin
            result_valid  <= 1'b1;
            result_index  <= cur.point_index;
            contrib_red   <= '1;
            contrib_green <= '1;
            contrib_blue  <= '1;
            saturated     <= 1'b1;
            state         <= S_IDLE;
          end else if (dbig) begin
            qq    <= '0;
            state <= S_FIN;
          end else begin
            for (int ch = 0; ch < 3; ch++) begin
              qr[ch] <= '0;
              qq[ch] <= {fl[ch], 32'd0};
            end
            cnt   <= '0;
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            qr[ch] <= q_ge[ch] ? (qr_sh[ch] - {1'b0, d}) : qr_sh[ch];
            qq[ch] <= {qq[ch][62:0], q_ge[ch]};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          logic [2:0]       c_sat;
          logic [2:0][31:0] c_val;
          for (int ch = 0; ch < 3; ch++) begin
            c_sat[ch] = (qq[ch][63:32] != '0) || e_sum[ch][32];
            c_val[ch] = c_sat[ch] ? '1 : e_sum[ch][31:0];
          end
          result_valid  <= 1'b1;
          result_index  <= cur.point_index;
          contrib_red   <= c_val[0];
          contrib_green <= c_val[1];
          contrib_blue  <= c_val[2];
          saturated     <= sat || (c_sat != 3'd0);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
